@@ rtl/rps_pkg.sv @@
// Shared constants and types for the random permutation shuffle unit.
package rps_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int COUNT_W      = 11;
    localparam int WORD_W       = 31;
    localparam int VERTEX_W     = 10;
    localparam int EPOCH_W      = 8;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

    // register indexes
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [IDX_W-1:0]   value;
    } store_entry_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        store_entry_t       data;
    } store_wr_t;

endpackage

@@ rtl/rps_if.sv @@
// Valid/ready channel interfaces for random words in and vertices out.
interface rps_word_if;
    logic                       valid;
    logic                       ready;
    logic [rps_pkg::WORD_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

interface rps_vertex_if;
    logic                         valid;
    logic                         ready;
    logic [rps_pkg::VERTEX_W-1:0] vertex;
    logic                         last;

    modport source (output valid, output vertex, output last, input ready);
    modport sink   (input valid, input vertex, input last, output ready);
endinterface

@@ rtl/rps_cfg.sv @@
// APB-style register port holding the vertex count.
module rps_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rps_pkg::APB_AW-1:0]  paddr,
    input  logic [rps_pkg::APB_DW-1:0]  pwdata,
    output logic [rps_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output logic [rps_pkg::COUNT_W-1:0] vertex_count
);

    logic [rps_pkg::COUNT_W-1:0] count_reg;
    logic [rps_pkg::COUNT_W-1:0] count_next;
    logic                        hit;

    assign hit    = (paddr[rps_pkg::APB_AW-1] == rps_pkg::REG_VERTEX_COUNT);
    assign pready = 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            count_next = pwdata[rps_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= rps_pkg::COUNT_RESET;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign prdata       = hit ? rps_pkg::APB_DW'(count_reg) : '0;
    assign vertex_count = count_reg;

endmodule

@@ rtl/rps_remainder.sv @@
// Bit-serial restoring remainder: word mod divisor, one quotient bit per cycle.
module rps_remainder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rps_pkg::WORD_W-1:0]  word,
    input  logic [rps_pkg::COUNT_W-1:0] divisor,
    output logic                        busy,
    output logic [rps_pkg::IDX_W-1:0]   rem
);

    localparam int CNT_W = $clog2(rps_pkg::WORD_W);
    localparam int CMP_W = rps_pkg::COUNT_W + rps_pkg::IDX_W + 1;

    logic [rps_pkg::WORD_W-1:0]  word_reg,    word_next;
    logic [rps_pkg::COUNT_W-1:0] div_reg,     div_next;
    logic [rps_pkg::IDX_W-1:0]   rem_reg,     rem_next;
    logic [CNT_W-1:0]            cnt_reg,     cnt_next;
    logic                        busy_reg,    busy_next;
    logic [CMP_W-1:0]            trial;
    logic [CMP_W-1:0]            div_ext;
    logic [CMP_W-1:0]            diff;

    assign trial   = CMP_W'({rem_reg, word_reg[rps_pkg::WORD_W-1]});
    assign div_ext = CMP_W'(div_reg);
    assign diff    = trial - div_ext;

    always_comb
    begin
        word_next = word_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            word_next = word;
            div_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // partial remainder stays below the divisor, so it fits the index width
            rem_next  = (trial >= div_ext) ? diff[rps_pkg::IDX_W-1:0]
                                           : trial[rps_pkg::IDX_W-1:0];
            word_next = {word_reg[rps_pkg::WORD_W-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(rps_pkg::WORD_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/rps_store.sv @@
// Permutation store: single-port-write, registered-read memory with epoch-tagged entries.
module rps_store (
    input  logic                        clk,
    input  rps_pkg::store_wr_t          wr,
    input  logic [rps_pkg::IDX_W-1:0]   rd_addr,
    input  logic [rps_pkg::EPOCH_W-1:0] cur_epoch,
    output logic [rps_pkg::IDX_W-1:0]   rd_value
);

    rps_pkg::store_entry_t       mem [rps_pkg::MAX_VERTICES];
    rps_pkg::store_entry_t       rd_data_reg;
    logic [rps_pkg::IDX_W-1:0]   rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    // an entry not written in the current permutation reads as its own index
    assign rd_value = (rd_data_reg.epoch == cur_epoch) ? rd_data_reg.value : rd_addr_reg;

endmodule

@@ rtl/random_permutation_shuffle_unit.sv @@
// Fisher-Yates shuffle top level: sequencer, position/epoch state and output register.
// One result per random word; a word is accepted only in the idle state, so the next word
// waits for the serial remainder, the read of entry j, the two store writes and the load
// of the output register, which stalls while the previous vertex is not yet taken.
// After reset, and after every 255 permutations, a clearing pass over all MAX_VERTICES
// (1024) store entries rewrites the store's epoch tags; no word is accepted during it.
module random_permutation_shuffle_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rps_pkg::APB_AW-1:0] paddr,
    input  logic [rps_pkg::APB_DW-1:0] pwdata,
    output logic [rps_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    rps_word_if.sink                   words,
    rps_vertex_if.source               verts
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_DIV   = 6'b000100,
        ST_WRJ   = 6'b001000,
        ST_WRI   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t                        state_reg, state_next;
    logic [rps_pkg::IDX_W-1:0]     pos_reg, pos_next;
    logic [rps_pkg::EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [rps_pkg::IDX_W-1:0]     clr_reg, clr_next;
    logic [rps_pkg::IDX_W-1:0]     i_reg, i_next;
    logic [rps_pkg::IDX_W-1:0]     j_reg, j_next;
    logic [rps_pkg::IDX_W-1:0]     a_reg, a_next;
    logic [rps_pkg::IDX_W-1:0]     b_reg, b_next;
    logic                          last_reg, last_next;
    logic                          out_valid_reg, out_valid_next;
    logic [rps_pkg::VERTEX_W-1:0]  out_vertex_reg, out_vertex_next;
    logic                          out_last_reg, out_last_next;

    logic [rps_pkg::COUNT_W-1:0]   vertex_count;
    logic [rps_pkg::COUNT_W-1:0]   n_eff;
    logic [rps_pkg::COUNT_W-1:0]   pos_ext;
    logic                          in_range;
    logic                          div_start;
    logic                          div_busy;
    logic [rps_pkg::IDX_W-1:0]     div_rem;
    rps_pkg::store_wr_t            wr;
    logic [rps_pkg::IDX_W-1:0]     rd_addr;
    logic [rps_pkg::IDX_W-1:0]     rd_value;

    rps_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .vertex_count (vertex_count)
    );

    rps_remainder u_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .word    (words.random_word),
        .divisor (n_eff - pos_ext),
        .busy    (div_busy),
        .rem     (div_rem)
    );

    rps_store u_store (
        .clk       (clk),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .cur_epoch (epoch_reg),
        .rd_value  (rd_value)
    );

    always_comb
    begin
        if (vertex_count == '0)
        begin
            n_eff = rps_pkg::COUNT_W'(1);
        end
        else if (vertex_count > rps_pkg::COUNT_W'(rps_pkg::MAX_VERTICES))
        begin
            n_eff = rps_pkg::COUNT_W'(rps_pkg::MAX_VERTICES);
        end
        else
        begin
            n_eff = vertex_count;
        end
    end

    assign pos_ext     = rps_pkg::COUNT_W'(pos_reg);
    assign in_range    = (pos_ext < n_eff);
    assign words.ready = (state_reg == ST_IDLE) && in_range;

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        epoch_next      = epoch_reg;
        clr_next        = clr_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !verts.ready;
        out_vertex_next = out_vertex_reg;
        out_last_next   = out_last_reg;
        div_start       = 1'b0;
        rd_addr         = i_reg;
        wr              = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr.en         = 1'b1;
                wr.addr       = clr_reg;
                wr.data.epoch = '0;
                wr.data.value = '0;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == rps_pkg::IDX_W'(rps_pkg::MAX_VERTICES - 1))
                begin
                    epoch_next = rps_pkg::EPOCH_W'(1);
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!in_range)
                begin
                    // count shrank to or below position: begin a fresh permutation
                    pos_next = '0;
                    if (epoch_reg == rps_pkg::EPOCH_MAX)
                    begin
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + 1'b1;
                    end
                end
                else if (words.valid)
                begin
                    i_next     = pos_reg;
                    last_next  = (pos_ext == n_eff - 1'b1);
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    a_next     = rd_value;
                    j_next     = i_reg + div_rem;
                    rd_addr    = i_reg + div_rem;
                    state_next = ST_WRJ;
                end
            end
            ST_WRJ:
            begin
                b_next        = rd_value;
                wr.en         = 1'b1;
                wr.addr       = j_reg;
                wr.data.epoch = epoch_reg;
                wr.data.value = a_reg;
                state_next    = ST_WRI;
            end
            ST_WRI:
            begin
                wr.en         = 1'b1;
                wr.addr       = i_reg;
                wr.data.epoch = epoch_reg;
                wr.data.value = b_reg;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || verts.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = rps_pkg::VERTEX_W'(b_reg);
                    out_last_next   = last_reg;
                    state_next      = ST_IDLE;
                    if (last_reg)
                    begin
                        pos_next = '0;
                        if (epoch_reg == rps_pkg::EPOCH_MAX)
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        pos_next = i_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            pos_reg       <= '0;
            epoch_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            epoch_reg     <= epoch_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        last_reg       <= last_next;
        out_vertex_reg <= out_vertex_next;
        out_last_reg   <= out_last_next;
    end

    assign verts.valid  = out_valid_reg;
    assign verts.vertex = out_vertex_reg;
    assign verts.last   = out_last_reg;

endmodule

@@ tb/rps_shuffle_checker.sv @@
// Shuffle checker: tracks the count register and the permutation, checks every vertex beat.
module rps_shuffle_checker
    import rps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    input  logic                word_valid,
    input  logic                word_ready,
    input  logic [WORD_W-1:0]   random_word,
    input  logic                vert_valid,
    input  logic                vert_ready,
    input  logic [VERTEX_W-1:0] vertex,
    input  logic                last,
    output int                  errors,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic                last;
    } placed_t;

    placed_t            placed_q[$];
    logic [COUNT_W-1:0] count_reg;
    logic [IDX_W-1:0]   slot [MAX_VERTICES];
    logic               slot_set [MAX_VERTICES];
    logic [IDX_W-1:0]   pos;

    function automatic logic [COUNT_W-1:0] active_count();
        if (count_reg == '0)
            return COUNT_W'(1);
        if (count_reg > COUNT_W'(MAX_VERTICES))
            return COUNT_W'(MAX_VERTICES);
        return count_reg;
    endfunction

    function automatic void restart();
        foreach (slot_set[k])
            slot_set[k] = 1'b0;
        pos = '0;
    endfunction

    // an untouched slot holds its own index
    function automatic logic [IDX_W-1:0] slot_value(input logic [IDX_W-1:0] k);
        return slot_set[k] ? slot[k] : k;
    endfunction

    function automatic placed_t shuffle_step(input logic [WORD_W-1:0] w);
        logic [COUNT_W-1:0] n;
        logic [COUNT_W-1:0] span;
        logic [IDX_W-1:0]   j;
        logic [IDX_W-1:0]   a;
        logic [IDX_W-1:0]   b;
        placed_t            r;
        n = active_count();
        // count may have dropped to or below the position since the last beat
        if ({1'b0, pos} >= n)
            restart();
        span = n - {1'b0, pos};
        j = pos + IDX_W'(w % span);
        a = slot_value(pos);
        b = slot_value(j);
        slot[j]      = a;
        slot_set[j]  = 1'b1;
        slot[pos]    = b;
        slot_set[pos] = 1'b1;
        r.vertex = b;
        r.last   = ({1'b0, pos} == n - COUNT_W'(1));
        if (r.last)
            restart();
        else
            pos = pos + 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        placed_t want;
        if (!rst_n)
        begin
            count_reg = COUNT_RESET;
            restart();
            placed_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && (paddr >> 2) == APB_AW'(REG_VERTEX_COUNT))
                count_reg = pwdata[COUNT_W-1:0];

            if (word_valid && word_ready)
                placed_q.push_back(shuffle_step(random_word));

            if (vert_valid && vert_ready)
            begin
                if (placed_q.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected vertex beat: expected none, got vertex %0d last %0b",
                             $time, vertex, last);
                end
                else
                begin
                    want = placed_q.pop_front();
                    if (vertex !== want.vertex)
                    begin
                        errors = errors + 1;
                        $display("%0t: vertex mismatch: expected %0d, got %0d",
                                 $time, want.vertex, vertex);
                    end
                    if (last !== want.last)
                    begin
                        errors = errors + 1;
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, last);
                    end
                end
            end
            pending = placed_q.size();
        end
    end

endmodule

@@ tb/tb_random_permutation_shuffle_unit.sv @@
// Testbench top: clock, reset, count register writes, random word stimulus and verdict.
module tb_random_permutation_shuffle_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import rps_pkg::*;

    typedef logic [WORD_W-1:0] word_t;

    localparam realtime CLK_HALF       = 6ns;
    localparam realtime RUN_LIMIT      = 15ms;
    localparam int      RESET_CYCLES   = 6;
    localparam int      REG_STRIDE     = 4;
    localparam int      REG_UNMAPPED   = 1;
    localparam int      ITEMS_PER_PASS = 460;
    localparam int      SETTLE_CYCLES  = 40;
    localparam int      SRC_IDLE[3]    = '{20, 87, 0};
    localparam int      SNK_IDLE[3]    = '{87, 20, 0};
    localparam word_t   OPENING_WORDS[6] = '{31'h0000_0000, 31'h7FFF_FFFF, 31'h0000_0001,
                                             31'h4000_0000, 31'h5555_5555, 31'h2AAA_AAAA};
    localparam logic [COUNT_W-1:0] EDGE_COUNTS[7] = '{11'd0, 11'd1, 11'd2, 11'd1023,
                                                      11'd1024, 11'd1025, 11'd2047};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                errors;
    int                pending;
    int                src_idle_pct;
    int                snk_idle_pct;
    word_t             batch[$];

    rps_word_if   words();
    rps_vertex_if verts();

    random_permutation_shuffle_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .words   (words),
        .verts   (verts)
    );

    rps_shuffle_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .word_valid  (words.valid),
        .word_ready  (words.ready),
        .random_word (words.random_word),
        .vert_valid  (verts.valid),
        .vert_ready  (verts.ready),
        .vertex      (verts.vertex),
        .last        (verts.last),
        .errors      (errors),
        .pending     (pending)
    );

    initial
        clk = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    always @(negedge clk)
        verts.ready = ($urandom_range(99) >= snk_idle_pct);

    initial
    begin
        #(RUN_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic word_t rand_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return word_t'($urandom_range(63));
            default: return word_t'($urandom);
        endcase
    endfunction

    // mostly short permutations so that many of them complete
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return EDGE_COUNTS[$urandom_range(6)];
        if (roll < 20)
            return COUNT_W'($urandom);
        if (roll < 50)
            return COUNT_W'($urandom_range(64, 9));
        return COUNT_W'($urandom_range(8, 1));
    endfunction

    task automatic apb_write(input int idx, input logic [APB_DW-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_AW'(idx * REG_STRIDE);
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // upper data bits are noise half of the time
    task automatic set_count(input logic [COUNT_W-1:0] cnt);
        logic [APB_DW-1:0] data;
        data = $urandom_range(1) ? APB_DW'($urandom) : '0;
        data[COUNT_W-1:0] = cnt;
        apb_write(int'(REG_VERTEX_COUNT), data);
    endtask

    task automatic queue_words(input int count);
        repeat (count)
            batch.push_back(rand_word());
    endtask

    task automatic send_batch();
        foreach (batch[k])
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                words.valid       = 1'b0;
                words.random_word = rand_word();
                @(negedge clk);
            end
            words.valid       = 1'b1;
            words.random_word = batch[k];
            @(posedge clk);
            while (!words.ready)
                @(posedge clk);
            @(negedge clk);
        end
        words.valid = 1'b0;
        batch.delete();
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int sent;
        int len;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        words.valid       = 1'b0;
        words.random_word = '0;
        verts.ready       = 1'b0;
        src_idle_pct      = 0;
        snk_idle_pct      = 50;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n = 1'b1;

        // reset count of 1024, word extremes
        foreach (OPENING_WORDS[k])
            batch.push_back(OPENING_WORDS[k]);
        send_batch();
        drain();

        // write to an unmapped register must not touch the count
        apb_write(REG_UNMAPPED, 32'h0000_0003);
        queue_words(2);
        send_batch();
        drain();

        // count drops below the current position: fresh permutation
        set_count(11'd5);
        queue_words(6);
        send_batch();
        drain();

        // zero count behaves as one
        set_count(11'd0);
        queue_words(3);
        send_batch();
        drain();

        // only the low count bits are kept
        apb_write(int'(REG_VERTEX_COUNT), 32'hFFFF_F802);
        queue_words(3);
        send_batch();
        drain();

        // counts past the store size saturate
        set_count(11'd2047);
        queue_words(2);
        send_batch();
        drain();
        set_count(11'd1025);
        queue_words(1);
        send_batch();
        drain();

        for (int pass = 0; pass < 3; pass++)
        begin
            src_idle_pct = SRC_IDLE[pass];
            snk_idle_pct = SNK_IDLE[pass];
            sent = 0;
            while (sent < ITEMS_PER_PASS)
            begin
                drain();
                if ($urandom_range(7) == 0)
                    apb_write(REG_UNMAPPED, $urandom);
                set_count(pick_count());
                len = $urandom_range(48, 1);
                queue_words(len);
                send_batch();
                sent += len;
            end
        end

        drain();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rps_pkg.sv
rtl/rps_if.sv
rtl/rps_cfg.sv
rtl/rps_remainder.sv
rtl/rps_store.sv
rtl/random_permutation_shuffle_unit.sv
tb/rps_shuffle_checker.sv
tb/tb_random_permutation_shuffle_unit.sv
